// File: rtl/core/csc_pkg.sv
package csc_pkg;

    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int ATAN_LEN   = 20;
    localparam int ATAN_IDX_W = 5;
    localparam int CORD_W     = 20;
    localparam int ANG_W      = 20;
    localparam int DIV_W      = 24;
    localparam int DVSR_W     = 10;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEC       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ILIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TI        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd7;

    localparam logic signed [15:0] TOP_X_MIN = -16'sd2000;
    localparam logic signed [15:0] TOP_X_MAX = 16'sd2000;
    localparam logic signed [15:0] TOP_Y_MIN = -16'sd2000;
    localparam logic signed [15:0] TOP_Y_MAX = 16'sd2000;
    localparam logic signed [15:0] TOP_Z_MIN = 16'sd14000;
    localparam logic signed [15:0] TOP_Z_MAX = 16'sd18000;

    typedef struct packed {
        logic [10:0] dist_min;
        logic [6:0]  corr;
        logic [6:0]  dec;
        logic [14:0] straight;
        logic [14:0] ilimit;
        logic [7:0]  kp;
        logic [9:0]  ti;
        logic [10:0] base;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TOP,
        OP_OBS,
        OP_CSTEP,
        OP_SCALE,
        OP_BMUL,
        OP_BADD,
        OP_BDIV,
        OP_INTEG,
        OP_PMUL,
        OP_PDIV,
        OP_FINAL,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_top;
        logic tilt_direct;
        logic cordic_last;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 20'd32768;
            5'd1:    v = 20'd19344;
            5'd2:    v = 20'd10221;
            5'd3:    v = 20'd5188;
            5'd4:    v = 20'd2604;
            5'd5:    v = 20'd1303;
            5'd6:    v = 20'd652;
            5'd7:    v = 20'd326;
            5'd8:    v = 20'd163;
            5'd9:    v = 20'd81;
            5'd10:   v = 20'd41;
            5'd11:   v = 20'd20;
            5'd12:   v = 20'd10;
            5'd13:   v = 20'd5;
            5'd14:   v = 20'd3;
            5'd15:   v = 20'd1;
            5'd16:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/climb_steering_controller.sv
// Channel   Direction  tdata (low bit up)                                   tuser
// s_        in         accel_x[15:0] accel_y[31:16] accel_z[47:32] distance[60:48] -
// m_        out        left_speed[15:0] right_speed[31:16] bearing[39:32]  at_top
// cfg_      in         write enable, register index, write data         -
//
// A non-top request takes two restoring-divider passes (24 quotient bits each) on its way
// to the output register, plus the CORDIC iterations when the tilt is not taken directly.
// A top-window request goes from acceptance through S_CHECK and S_OUT to the output register.
// The next request is taken the cycle after a result is loaded; a full output
// register holds the controller before the load and keeps s_tready low.
// Synchronous active-low reset idles control, loads config defaults, clears controller state.
module climb_steering_controller
    import csc_pkg::*;
#(
    parameter int BEARING_LIMIT = 100,
    parameter int ATAN_STEPS    = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z, distance_mm
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // left_speed, right_speed, blended_bearing
    output logic                  m_tuser,   // at_top
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_min <= 11'd100;
            cfg_reg.corr     <= 7'd60;
            cfg_reg.dec      <= 7'd1;
            cfg_reg.straight <= 15'd100;
            cfg_reg.ilimit   <= 15'd1000;
            cfg_reg.kp       <= 8'd5;
            cfg_reg.ti       <= 10'd20;
            cfg_reg.base     <= 11'd500;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIST_MIN: cfg_reg.dist_min <= cfg_wdata[10:0];
                REG_CORR:     cfg_reg.corr     <= cfg_wdata[6:0];
                REG_DEC:      cfg_reg.dec      <= cfg_wdata[6:0];
                REG_STRAIGHT: cfg_reg.straight <= cfg_wdata[14:0];
                REG_ILIMIT:   cfg_reg.ilimit   <= cfg_wdata[14:0];
                REG_KP:       cfg_reg.kp       <= cfg_wdata[7:0];
                REG_TI:       cfg_reg.ti       <= cfg_wdata[9:0];
                REG_BASE:     cfg_reg.base     <= cfg_wdata[10:0];
                default:      cfg_reg.base     <= cfg_reg.base;
            endcase
        end
    end

    csc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csc_dp #(
        .BEARING_LIMIT (BEARING_LIMIT),
        .ATAN_STEPS    (ATAN_STEPS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("top result with nonzero payload");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no request in work");
`endif

endmodule

// File: rtl/core/csc_div.sv
module csc_div
    import csc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quot
);

    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DVSR_W:0]      trial;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        if (busy_reg) begin
            if (trial >= {1'b0, dvsr_reg}) begin
                rem_next  = DVSR_W'(trial - {1'b0, dvsr_reg});
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DVSR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvsr_reg <= divisor;
        end else begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/core/csc_dp.sv
module csc_dp
    import csc_pkg::*;
#(
    parameter int BEARING_LIMIT = 100,
    parameter int ATAN_STEPS    = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int STEPS = (ATAN_STEPS > ATAN_LEN) ? ATAN_LEN : ATAN_STEPS;
    localparam logic [7:0] LIM8 = 8'(BEARING_LIMIT);

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [12:0]        dist_reg;
    logic signed [7:0]  obs_reg;
    logic               turn_reg;
    logic signed [15:0] sum_reg;
    logic signed [7:0]  tilt_reg;
    logic signed [CORD_W-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [ATAN_IDX_W-1:0]    iter_reg;
    logic signed [16:0] proda_reg;
    logic signed [17:0] num_reg;
    logic               neg_reg;
    logic signed [7:0]  bear_reg;
    logic signed [16:0] pk_reg;
    logic signed [24:0] ps_reg;
    logic [15:0]        left_reg, right_reg;
    logic [7:0]         rbear_reg;
    logic               rtop_reg;
    logic               mvalid_reg;
    logic [M_TDATA_W-1:0] mdata_reg;
    logic               muser_reg;

    logic [6:0]  corrd;
    logic [9:0]  tid;
    logic [16:0] ax_abs;
    logic        straight, tilt_low;
    logic signed [CORD_W-1:0] shx, shy;
    logic [ANG_W-1:0]  z_abs, atan_v;
    logic [ANG_W+7:0]  mag_prod;
    logic [7:0]        clip;
    logic signed [8:0] diff;
    logic [DIV_W-1:0]  dvd;
    logic [DVSR_W-1:0] dvs;
    logic              div_start, div_busy;
    logic [DIV_W-1:0]  quot;
    logic [15:0]       q16, delta, base16;
    logic signed [7:0] bear_new;
    logic signed [16:0] sum_abs, ilim17, sum17;
    logic              integ_ok;
    logic [7:0]        obs_abs;
    logic signed [8:0] obs_left;

    function automatic logic signed [CORD_W-1:0] tdiv(input logic signed [CORD_W-1:0] v,
                                                      input logic [ATAN_IDX_W-1:0] sh);
        logic signed [CORD_W-1:0] r;
        if (v < 0) begin
            r = -((-v) >>> sh);
        end else begin
            r = v >>> sh;
        end
        return r;
    endfunction

    assign corrd  = (cfg.corr == '0) ? 7'd1 : cfg.corr;
    assign tid    = (cfg.ti == '0) ? 10'd1 : cfg.ti;
    assign ax_abs = ax_reg[15] ? 17'(-{ax_reg[15], ax_reg}) : {1'b0, ax_reg};
    assign straight = (ax_abs <= {2'b0, cfg.straight}) && (ay_reg > 16'sd0);
    assign tilt_low = ay_reg < TOP_Y_MAX;

    assign shx    = tdiv(cx_reg, iter_reg);
    assign shy    = tdiv(cy_reg, iter_reg);
    assign atan_v = atan_entry(iter_reg);

    assign z_abs    = z_reg[ANG_W-1] ? ANG_W'(-z_reg) : ANG_W'(z_reg);
    assign mag_prod = {8'b0, z_abs} * {20'b0, LIM8};
    assign clip     = (mag_prod[ANG_W+7:16] > {4'b0, LIM8}) ? LIM8 : mag_prod[23:16];

    assign obs_abs  = obs_reg[7] ? 8'(-obs_reg) : 8'(obs_reg);
    assign obs_left = $signed({1'b0, obs_abs}) - $signed({2'b0, cfg.dec});
    assign diff     = $signed({2'b0, cfg.corr}) - $signed({1'b0, obs_abs});

    assign q16      = neg_reg ? 16'(-quot[15:0]) : quot[15:0];
    assign bear_new = $signed(q16[7:0]);
    assign sum17    = {sum_reg[15], sum_reg};
    assign sum_abs  = sum_reg[15] ? -sum17 : sum17;
    assign ilim17   = $signed({2'b0, cfg.ilimit});
    assign integ_ok = (sum_abs < ilim17) || (sum17 >= ilim17 && bear_new < 0) ||
                      (sum17 <= -ilim17 && bear_new > 0);

    assign base16 = {5'b0, cfg.base};
    assign delta  = pk_reg[15:0] + q16;

    always_comb begin
        div_start = 1'b0;
        dvd = '0;
        dvs = '0;
        case (cmd.op)
            OP_BDIV: begin
                div_start = 1'b1;
                dvd = num_reg[17] ? DIV_W'(-num_reg) : DIV_W'(num_reg);
                dvs = {3'b0, corrd};
            end
            OP_PDIV: begin
                div_start = 1'b1;
                dvd = ps_reg[24] ? DIV_W'(-ps_reg) : DIV_W'(ps_reg);
                dvs = tid;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    csc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .quot     (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_reg  <= '0;
            turn_reg <= 1'b0;
            sum_reg  <= '0;
        end else begin
            case (cmd.op)
                OP_OBS: begin
                    if ({2'b0, dist_reg} <= {2'b0, cfg.dist_min}) begin
                        obs_reg <= turn_reg ? -$signed({1'b0, cfg.corr})
                                            : $signed({1'b0, cfg.corr});
                    end else if (obs_reg != 0) begin
                        if (obs_left > 0) begin
                            obs_reg <= turn_reg ? 8'(-obs_left) : 8'(obs_left);
                        end else begin
                            obs_reg  <= '0;
                            turn_reg <= ~turn_reg;
                        end
                    end
                end
                OP_INTEG: begin
                    if (integ_ok) begin
                        sum_reg <= sum_reg + 16'(bear_new);
                    end
                end
                default: begin
                    sum_reg <= sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                ax_reg   <= $signed(s_tdata[15:0]);
                ay_reg   <= $signed(s_tdata[31:16]);
                az_reg   <= $signed(s_tdata[47:32]);
                dist_reg <= s_tdata[60:48];
            end
            OP_TOP: begin
                left_reg  <= '0;
                right_reg <= '0;
                rbear_reg <= '0;
                rtop_reg  <= 1'b1;
            end
            OP_OBS: begin
                if (straight) begin
                    tilt_reg <= '0;
                end else begin
                    tilt_reg <= (ax_reg >= 0) ? -$signed(LIM8) : $signed(LIM8);
                end
                cx_reg   <= CORD_W'(ay_reg);
                cy_reg   <= CORD_W'(ax_reg);
                z_reg    <= '0;
                iter_reg <= '0;
            end
            OP_CSTEP: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + shy;
                    cy_reg <= cy_reg - shx;
                    z_reg  <= z_reg + $signed(atan_v);
                end else begin
                    cx_reg <= cx_reg - shy;
                    cy_reg <= cy_reg + shx;
                    z_reg  <= z_reg - $signed(atan_v);
                end
                iter_reg <= iter_reg + 1'b1;
            end
            OP_SCALE: begin
                tilt_reg <= z_reg[ANG_W-1] ? $signed(clip) : -$signed(clip);
            end
            OP_BMUL: begin
                proda_reg <= diff * tilt_reg;
            end
            OP_BADD: begin
                num_reg <= 18'(proda_reg) + 18'(obs_reg * $signed({1'b0, corrd}));
            end
            OP_BDIV: begin
                neg_reg <= num_reg[17];
            end
            OP_INTEG: begin
                bear_reg <= bear_new;
            end
            OP_PMUL: begin
                pk_reg <= $signed({1'b0, cfg.kp}) * bear_reg;
                ps_reg <= $signed({1'b0, cfg.kp}) * sum_reg;
            end
            OP_PDIV: begin
                neg_reg <= ps_reg[24];
            end
            OP_FINAL: begin
                left_reg  <= base16 - delta;
                right_reg <= base16 + delta;
                rbear_reg <= bear_reg;
                rtop_reg  <= 1'b0;
            end
            default: begin
                rtop_reg <= rtop_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.op == OP_PUSH) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PUSH) begin
            mdata_reg <= {rbear_reg, right_reg, left_reg};
            muser_reg <= rtop_reg;
        end
    end

    assign stat.is_top = (ax_reg > TOP_X_MIN) && (ax_reg < TOP_X_MAX) &&
                         (ay_reg > TOP_Y_MIN) && (ay_reg < TOP_Y_MAX) &&
                         (az_reg > TOP_Z_MIN) && (az_reg < TOP_Z_MAX);
    assign stat.tilt_direct = straight || tilt_low;
    assign stat.cordic_last = (iter_reg == ATAN_IDX_W'(STEPS - 1));
    assign stat.div_done    = !div_busy;
    assign stat.out_free    = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// File: rtl/core/csc_ctrl.sv
module csc_ctrl
    import csc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CORDIC,
        S_SCALE,
        S_BMUL,
        S_BADD,
        S_BDIV,
        S_BWAIT,
        S_PMUL,
        S_PDIV,
        S_PWAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.is_top) begin
                    cmd.op     = OP_TOP;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_OBS;
                    state_next = stat.tilt_direct ? S_BMUL : S_CORDIC;
                end
            end
            S_CORDIC: begin
                cmd.op = OP_CSTEP;
                if (stat.cordic_last) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = S_BMUL;
            end
            S_BMUL: begin
                cmd.op     = OP_BMUL;
                state_next = S_BADD;
            end
            S_BADD: begin
                cmd.op     = OP_BADD;
                state_next = S_BDIV;
            end
            S_BDIV: begin
                cmd.op     = OP_BDIV;
                state_next = S_BWAIT;
            end
            S_BWAIT: begin
                if (stat.div_done) begin
                    cmd.op     = OP_INTEG;
                    state_next = S_PMUL;
                end
            end
            S_PMUL: begin
                cmd.op     = OP_PMUL;
                state_next = S_PDIV;
            end
            S_PDIV: begin
                cmd.op     = OP_PDIV;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                if (stat.div_done) begin
                    cmd.op     = OP_FINAL;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: test/climb_steering_controller_tb.sv
`timescale 1ns / 100ps

module climb_steering_controller_tb
    import csc_pkg::*;
();

    localparam int TILT_LIMIT  = 100;
    localparam int CORDIC_LEN  = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM    = 1330;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [12:0]        range_mm;
    } request_t;

    typedef struct packed {
        logic signed [15:0] left_spd;
        logic signed [15:0] right_spd;
        logic               at_top;
        logic signed [7:0]  bearing;
    } steer_t;

    class steer_scoreboard;
        cfg_t               regs;
        logic signed [7:0]  obs_brg;
        logic               turn_right;
        logic signed [15:0] integ;
        steer_t             pending[$];
        int                 n_errors;
        int                 n_checked;
        int                 n_top;
        int                 n_cordic;

        function new();
            n_errors = 0;
            n_checked = 0;
            n_top = 0;
            n_cordic = 0;
            obs_brg = 0;
            turn_right = 0;
            integ = 0;
            regs = '{dist_min: 11'd100, corr: 7'd60, dec: 7'd1, straight: 15'd100,
                     ilimit: 15'd1000, kp: 8'd5, ti: 10'd20, base: 11'd500};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_DIST_MIN: regs.dist_min = v[10:0];
                REG_CORR:     regs.corr     = v[6:0];
                REG_DEC:      regs.dec      = v[6:0];
                REG_STRAIGHT: regs.straight = v[14:0];
                REG_ILIMIT:   regs.ilimit   = v[14:0];
                REG_KP:       regs.kp       = v[7:0];
                REG_TI:       regs.ti       = v[9:0];
                REG_BASE:     regs.base     = v[10:0];
                default: ;
            endcase
        endfunction

        function int tilt_angle(int ax, int ay);
            longint cx, cy, z, nx, ny, d, mag;
            int b;
            z = 0;
            if ((ax < 0 ? -ax : ax) <= int'(regs.straight) && ay > 0) return 0;
            if (ay < 2000) return ax >= 0 ? -TILT_LIMIT : TILT_LIMIT;
            n_cordic++;
            cx = ay;
            cy = ax;
            for (int i = 0; i < CORDIC_LEN; i++) begin
                d = longint'(1) << i;
                if (cy > 0) begin
                    nx = cx + cy / d;
                    ny = cy - cx / d;
                    z += atan_entry(i[4:0]);
                end else begin
                    nx = cx - cy / d;
                    ny = cy + cx / d;
                    z -= atan_entry(i[4:0]);
                end
                cx = nx;
                cy = ny;
            end
            mag = (z < 0 ? -z : z) * TILT_LIMIT / 65536;
            b = int'(z < 0 ? mag : -mag);
            if (b > TILT_LIMIT) b = TILT_LIMIT;
            if (b < -TILT_LIMIT) b = -TILT_LIMIT;
            return b;
        endfunction

        function void note_request(request_t r);
            steer_t e;
            int sgn, m, rest, tilt, oabs, corr, brg, sabs, ilim, ti;
            longint num, dl;
            e = '0;
            if (r.ax > -2000 && r.ax < 2000 && r.ay > -2000 && r.ay < 2000 &&
                r.az > 14000 && r.az < 18000) begin
                e.at_top = 1'b1;
                n_top++;
                pending.push_back(e);
                return;
            end
            sgn = turn_right ? -1 : 1;
            if (r.range_mm <= regs.dist_min) begin
                obs_brg = 8'(sgn * int'(regs.corr));
            end else if (obs_brg != 0) begin
                m = obs_brg < 0 ? -int'(obs_brg) : int'(obs_brg);
                rest = m - int'(regs.dec);
                if (rest > 0) obs_brg = 8'(sgn * rest);
                else begin
                    obs_brg = 0;
                    turn_right = ~turn_right;
                end
            end
            tilt = tilt_angle(int'(r.ax), int'(r.ay));
            oabs = obs_brg < 0 ? -int'(obs_brg) : int'(obs_brg);
            corr = regs.corr == 0 ? 1 : int'(regs.corr);
            num = longint'(int'(regs.corr) - oabs) * tilt + longint'(obs_brg) * corr;
            e.bearing = 8'(num / corr);
            brg = int'(e.bearing);
            ilim = int'(regs.ilimit);
            sabs = integ < 0 ? -int'(integ) : int'(integ);
            if (sabs < ilim || (int'(integ) >= ilim && brg < 0) ||
                (int'(integ) <= -ilim && brg > 0))
                integ = 16'(int'(integ) + brg);
            ti = regs.ti == 0 ? 1 : int'(regs.ti);
            dl = longint'(regs.kp) * brg + (longint'(regs.kp) * int'(integ)) / ti;
            e.left_spd = 16'(longint'(regs.base) - longint'(signed'(16'(dl))));
            e.right_spd = 16'(longint'(regs.base) + longint'(signed'(16'(dl))));
            pending.push_back(e);
        endfunction

        function void check_result(steer_t got);
            steer_t e;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.left_spd !== e.left_spd || got.right_spd !== e.right_spd ||
                got.at_top !== e.at_top || got.bearing !== e.bearing) begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"mismatch #%0d: exp L=%0d R=%0d top=%0d b=%0d",
                              " got L=%0d R=%0d top=%0d b=%0d"},
                             n_checked, e.left_spd, e.right_spd, e.at_top, e.bearing,
                             got.left_spd, got.right_spd, got.at_top, got.bearing);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    steer_scoreboard sb;
    bit  rx_idle_on;
    bit  rx_hold;
    int  quiet_cycles;
    bit  sent_all;

    climb_steering_controller u_top (.*);

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (rx_hold) begin
                m_tready = 1'b0;
                repeat (600) @(negedge aclk);
                rx_hold = 0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{left_spd: m_tdata[15:0], right_spd: m_tdata[31:16],
                              at_top: m_tuser, bearing: m_tdata[39:32]});
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("climb_steering_controller_tb: errors");
            $finish;
        end
    end

    task automatic send_request(request_t r, bit gaps);
        int n;
        if (gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, r.range_mm, r.az, r.ay, r.ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(v);
        sb.write_reg(idx, CFG_DATA_W'(v));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic request_t rand_request();
        request_t r;
        int k;
        k = $urandom_range(0, 9);
        r.ax = 16'($urandom);
        r.ay = 16'($urandom);
        r.az = 16'($urandom);
        r.range_mm = 13'($urandom_range(0, 300));
        if (k == 0) begin
            r.ax = 16'($urandom_range(0, 3998) - 1999);
            r.ay = 16'($urandom_range(0, 3998) - 1999);
            r.az = 16'($urandom_range(14001, 17999));
        end else if (k <= 5) begin
            r.ay = 16'($urandom_range(2000, 32767));
            r.ax = 16'($urandom_range(0, 40000) - 20000);
        end else if (k <= 6) begin
            r.ax = 16'($urandom_range(0, 400) - 200);
        end
        if ($urandom_range(0, 3) == 0) r.range_mm = 13'($urandom);
        return r;
    endfunction

    task automatic random_phase(int n, bit gaps);
        for (int i = 0; i < n; i++) send_request(rand_request(), gaps);
        drain();
    endtask

    initial begin
        request_t d;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DIST_MIN;
        cfg_wdata = '0;
        rx_idle_on = 1;
        rx_hold = 0;
        quiet_cycles = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: top window edges, extremes, straight, obstacle set and decay
        send_request('{16'sd0, 16'sd0, 16'sd16000, 13'd5000}, 0);
        send_request('{16'sd1999, -16'sd1999, 16'sd14001, 13'd0}, 0);
        send_request('{16'sd2000, 16'sd0, 16'sd16000, 13'd5000}, 0);
        send_request('{16'sd0, 16'sd0, 16'sd18000, 13'd5000}, 0);
        send_request('{16'sd0, 16'sd0, 16'sd14000, 13'd5000}, 0);
        send_request('{16'sd50, 16'sd5000, 16'sd0, 13'd8191}, 0);
        send_request('{16'sd100, 16'sd1, 16'sd0, 13'd8191}, 0);
        send_request('{16'sd101, 16'sd0, 16'sd0, 13'd8191}, 0);
        send_request('{-16'sd32768, -16'sd32768, -16'sd32768, 13'd100}, 0);
        send_request('{16'sd32767, 16'sd32767, 16'sd32767, 13'd101}, 0);
        send_request('{16'sd32767, 16'sd1999, 16'sd0, 13'd0}, 0);
        send_request('{-16'sd5000, 16'sd2000, 16'sd0, 13'd8191}, 0);
        send_request('{16'sd5000, 16'sd3000, 16'sd0, 13'd8191}, 0);
        send_request('{-16'sd20000, 16'sd2500, 16'sd0, 13'd4000}, 0);
        send_request('{16'sd20000, 16'sd2500, 16'sd0, 13'd4000}, 0);
        send_request('{16'sd0, -16'sd5000, 16'sd0, 13'd4000}, 0);
        drain();

        write_reg(REG_CORR, 3);
        write_reg(REG_DEC, 1);
        write_reg(REG_DIST_MIN, 0);
        d = '{16'sd3000, 16'sd9000, 16'sd0, 13'd0};
        send_request(d, 0);
        d.range_mm = 13'd8191;
        for (int i = 0; i < 6; i++) send_request(d, 0);
        drain();

        // defaults with random traffic and a long output hold-off
        write_reg(REG_DIST_MIN, 100);
        write_reg(REG_CORR, 60);
        rx_hold = 1;
        random_phase(300, 1);

        write_reg(REG_DIST_MIN, 2047);
        write_reg(REG_CORR, 127);
        write_reg(REG_DEC, 127);
        write_reg(REG_STRAIGHT, 32767);
        write_reg(REG_ILIMIT, 32767);
        write_reg(REG_KP, 255);
        write_reg(REG_TI, 1);
        write_reg(REG_BASE, 2047);
        random_phase(250, 1);

        write_reg(REG_DIST_MIN, 0);
        write_reg(REG_CORR, 0);
        write_reg(REG_DEC, 0);
        write_reg(REG_STRAIGHT, 0);
        write_reg(REG_ILIMIT, 0);
        write_reg(REG_KP, 0);
        write_reg(REG_TI, 0);
        write_reg(REG_BASE, 0);
        random_phase(200, 1);

        write_reg(REG_DIST_MIN, 200);
        write_reg(REG_CORR, 1);
        write_reg(REG_DEC, 3);
        write_reg(REG_STRAIGHT, 500);
        write_reg(REG_ILIMIT, 300);
        write_reg(REG_KP, 17);
        write_reg(REG_TI, 1023);
        write_reg(REG_BASE, 1000);
        random_phase(300, 1);

        write_reg(REG_CORR, 40);
        write_reg(REG_DEC, 5);
        write_reg(REG_KP, 9);
        write_reg(REG_TI, 7);
        rx_idle_on = 0;
        random_phase(N_RANDOM - 1050, 0);

        $display("covered %0d results (%0d top-window, %0d arctangent) over default,",
                 sb.n_checked, sb.n_top, sb.n_cordic);
        $display("extreme, zero and mid-range registers, with stalls and a long hold-off");
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("climb_steering_controller_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending.size());
            $display("climb_steering_controller_tb: errors");
        end
        $finish;
    end

endmodule
